// File: rtl/core/pedal_plausibility_monitor_top_defines.svh
// assertion macros for the pedal plausibility monitor
`ifndef PEDAL_PLAUSIBILITY_MONITOR_TOP_DEFINES_SVH
`define PEDAL_PLAUSIBILITY_MONITOR_TOP_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define PPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define PPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ppm_pkg.sv
// shared types and constants of the pedal plausibility monitor
`timescale 1ns / 1ps

package ppm_pkg;

  localparam int TRAVEL_W = 10;
  localparam int BRAKE_W  = 12;
  localparam int STAMP_W  = 32;
  localparam int DELAY_W  = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DELAY    = 3'd0;
  localparam logic [2:0] REG_DISAGREE = 3'd1;
  localparam logic [2:0] REG_BEGIN    = 3'd2;
  localparam logic [2:0] REG_END      = 3'd3;
  localparam logic [2:0] REG_BRAKE    = 3'd4;

  // register reset values
  localparam logic [DELAY_W-1:0]  RST_DELAY    = 16'd100;
  localparam logic [TRAVEL_W-1:0] RST_DISAGREE = 10'd100;
  localparam logic [TRAVEL_W-1:0] RST_BEGIN    = 10'd250;
  localparam logic [TRAVEL_W-1:0] RST_END      = 10'd50;
  localparam logic [BRAKE_W-1:0]  RST_BRAKE    = 12'd600;

  typedef struct packed {
    logic [DELAY_W-1:0]  delay_ms;
    logic [TRAVEL_W-1:0] disagree;
    logic [TRAVEL_W-1:0] begin_travel;
    logic [TRAVEL_W-1:0] end_travel;
    logic [BRAKE_W-1:0]  brake_limit;
  } ppm_cfg_t;

  typedef struct packed {
    logic               seen;
    logic               reported;
    logic [STAMP_W-1:0] start_stamp;
    logic               conflict;
  } ppm_state_t;

endpackage

// File: rtl/core/pedal_plausibility_monitor_top.sv
// top level of the pedal plausibility monitor
//
//   channel   direction  handshake          payload
//   in_       sink       in_valid/in_stall  throttle_a, throttle_b, brake_raw, stamp_ms
//   out_      source     out_valid/out_stall implausible, disagreeing, conflict
//   cfg       apb slave  psel/penable/pready paddr, pwdata, prdata
//
// one transaction per cycle sustained while out_stall is low; a result passes the
// input register, then the result register; the check is compares, a 10-bit and a
// 32-bit subtraction. synchronous active-low reset resets the state, valid flags
// and config registers. a stalled result keeps one more transaction in the input
// register; in_stall rises only when both registers are full and out_stall is high.
`timescale 1ns / 1ps

module pedal_plausibility_monitor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ppm_pkg::TRAVEL_W-1:0]  in_throttle_a,
  input  logic [ppm_pkg::TRAVEL_W-1:0]  in_throttle_b,
  input  logic [ppm_pkg::BRAKE_W-1:0]   in_brake_raw,
  input  logic [ppm_pkg::STAMP_W-1:0]   in_stamp_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_implausible,
  output logic                          out_disagreeing,
  output logic                          out_conflict,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppm_pkg::ADDR_W-1:0]    paddr,
  input  logic [ppm_pkg::DATA_W-1:0]    pwdata,
  output logic [ppm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  ppm_pkg::ppm_cfg_t   cfg;
  ppm_pkg::ppm_state_t state_r;
  ppm_pkg::ppm_state_t state_nxt;

  // input register
  logic                          s1_valid_r;
  logic [ppm_pkg::TRAVEL_W-1:0]  s1_a_r;
  logic [ppm_pkg::TRAVEL_W-1:0]  s1_b_r;
  logic [ppm_pkg::BRAKE_W-1:0]   s1_brake_r;
  logic [ppm_pkg::STAMP_W-1:0]   s1_stamp_r;

  // result register
  logic out_valid_r;
  logic out_implausible_r;
  logic out_disagreeing_r;
  logic out_conflict_r;

  logic disagreeing;
  logic advance;
  logic in_take;

  ppm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppm_check u_check (
    .cfg         (cfg),
    .state       (state_r),
    .throttle_a  (s1_a_r),
    .throttle_b  (s1_b_r),
    .brake_raw   (s1_brake_r),
    .stamp_ms    (s1_stamp_r),
    .state_nxt   (state_nxt),
    .disagreeing (disagreeing)
  );

  // the sample moves on when the result register is free or being emptied
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_a_r     <= in_throttle_a;
      s1_b_r     <= in_throttle_b;
      s1_brake_r <= in_brake_raw;
      s1_stamp_r <= in_stamp_ms;
    end
  end

  // monitor state follows each sample exactly once, as it leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_implausible_r <= state_nxt.reported;
      out_disagreeing_r <= disagreeing;
      out_conflict_r    <= state_nxt.conflict;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_implausible = out_implausible_r;
  assign out_disagreeing = out_disagreeing_r;
  assign out_conflict    = out_conflict_r;

`include "pedal_plausibility_monitor_top_defines.svh"

  // a report is only raised inside a disagreement run
  `PPM_ASSERT(a_report_needs_seen, state_r.reported |-> state_r.seen, "report without disagreement run")
  // an implausible result always comes with a disagreeing sample
  `PPM_ASSERT(a_impl_disagree, out_valid_r && out_implausible_r |-> out_disagreeing_r, "implausible while agreeing")
  // back-pressure only when a sample is actually held
  `PPM_ASSERT(a_stall_holds, in_stall |-> s1_valid_r && out_valid_r && out_stall, "spurious input stall")
  // reset empties the pipeline
  `PPM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not empty after reset")

endmodule

// File: rtl/core/ppm_cfg_regs.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps

module ppm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppm_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppm_pkg::DATA_W-1:0]   pwdata,
  output logic [ppm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ppm_pkg::ppm_cfg_t            cfg
);

  ppm_pkg::ppm_cfg_t cfg_r;
  ppm_pkg::ppm_cfg_t cfg_nxt;
  logic              wr_en;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ppm_pkg::ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        ppm_pkg::REG_DELAY:    cfg_nxt.delay_ms     = pwdata[ppm_pkg::DELAY_W-1:0];
        ppm_pkg::REG_DISAGREE: cfg_nxt.disagree     = pwdata[ppm_pkg::TRAVEL_W-1:0];
        ppm_pkg::REG_BEGIN:    cfg_nxt.begin_travel = pwdata[ppm_pkg::TRAVEL_W-1:0];
        ppm_pkg::REG_END:      cfg_nxt.end_travel   = pwdata[ppm_pkg::TRAVEL_W-1:0];
        ppm_pkg::REG_BRAKE:    cfg_nxt.brake_limit  = pwdata[ppm_pkg::BRAKE_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ms     <= ppm_pkg::RST_DELAY;
      cfg_r.disagree     <= ppm_pkg::RST_DISAGREE;
      cfg_r.begin_travel <= ppm_pkg::RST_BEGIN;
      cfg_r.end_travel   <= ppm_pkg::RST_END;
      cfg_r.brake_limit  <= ppm_pkg::RST_BRAKE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      ppm_pkg::REG_DELAY:    prdata = {16'd0, cfg_r.delay_ms};
      ppm_pkg::REG_DISAGREE: prdata = {22'd0, cfg_r.disagree};
      ppm_pkg::REG_BEGIN:    prdata = {22'd0, cfg_r.begin_travel};
      ppm_pkg::REG_END:      prdata = {22'd0, cfg_r.end_travel};
      ppm_pkg::REG_BRAKE:    prdata = {20'd0, cfg_r.brake_limit};
      default:               prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/ppm_check.sv
// combinational plausibility and conflict checks for one sample
`timescale 1ns / 1ps

module ppm_check (
  input  ppm_pkg::ppm_cfg_t               cfg,
  input  ppm_pkg::ppm_state_t             state,
  input  logic [ppm_pkg::TRAVEL_W-1:0]    throttle_a,
  input  logic [ppm_pkg::TRAVEL_W-1:0]    throttle_b,
  input  logic [ppm_pkg::BRAKE_W-1:0]     brake_raw,
  input  logic [ppm_pkg::STAMP_W-1:0]     stamp_ms,
  output ppm_pkg::ppm_state_t             state_nxt,
  output logic                            disagreeing
);

  logic [ppm_pkg::TRAVEL_W-1:0] hi;
  logic [ppm_pkg::TRAVEL_W-1:0] lo;
  logic [ppm_pkg::STAMP_W-1:0]  elapsed;

  assign hi          = (throttle_a > throttle_b) ? throttle_a : throttle_b;
  assign lo          = (throttle_a > throttle_b) ? throttle_b : throttle_a;
  assign disagreeing = (hi - lo) >= cfg.disagree;
  assign elapsed     = stamp_ms - state.start_stamp;

  always_comb begin
    state_nxt = state;
    if (!disagreeing) begin
      state_nxt.seen     = 1'b0;
      state_nxt.reported = 1'b0;
    end else if (!state.seen) begin
      state_nxt.seen        = 1'b1;
      state_nxt.start_stamp = stamp_ms;
    end else begin
      state_nxt.reported = elapsed > {16'd0, cfg.delay_ms};
    end

    // conflict is frozen while an implausibility is reported
    if (!state_nxt.reported) begin
      if (state.conflict) begin
        state_nxt.conflict = lo >= cfg.end_travel;
      end else begin
        state_nxt.conflict = (brake_raw > cfg.brake_limit) && (lo > cfg.begin_travel);
      end
    end
  end

endmodule
